/* rtl/ddos_pkg.sv */
// Shared constants, types and CORDIC tables for the slip-aware odometry block.
package ddos_pkg;

   localparam int DeltaWidthDefault = 16;
   localparam int AngleWidthDefault = 16;
   localparam int CsrIndexWidth     = 3;
   localparam int CsrDataWidth      = 31;
   localparam int CordicSteps       = 16;

   typedef enum logic [1:0] {
      CMD_ODO  = 2'd0,
      CMD_MOTOR = 2'd1,
      CMD_SET  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_ODO_MM     = 3'd0,
      CSR_ODO_ANGLE  = 3'd1,
      CSR_MOTOR_MM   = 3'd2,
      CSR_HALF_TRACK = 3'd3,
      CSR_SLIP_LIMIT = 3'd4
   } csr_index_type;

   localparam logic signed [31:0] CordicGain = 32'sd163008219;

   // Arctangent of 2^-i as a fraction of a 32-bit turn.
   function automatic logic signed [31:0] atan_turn(input logic [3:0] i);
      logic signed [31:0] r;
      case (i)
         4'd0: r = 32'sd536870912;
         4'd1: r = 32'sd316933406;
         4'd2: r = 32'sd167458907;
         4'd3: r = 32'sd85004756;
         4'd4: r = 32'sd42667331;
         4'd5: r = 32'sd21354465;
         4'd6: r = 32'sd10680350;
         4'd7: r = 32'sd5340245;
         4'd8: r = 32'sd2670163;
         4'd9: r = 32'sd1335087;
         4'd10: r = 32'sd667544;
         4'd11: r = 32'sd333772;
         4'd12: r = 32'sd166886;
         4'd13: r = 32'sd83443;
         4'd14: r = 32'sd41721;
         default: r = 32'sd20860;
      endcase
      return r;
   endfunction

   // Saturate a wide signed value into 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] r;
      if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -72'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

/* rtl/ddos_req_if.sv */
// Handshake interface for input words of the odometry block.
interface ddos_req_if
   import ddos_pkg::*;
#(
   parameter int DELTA_WIDTH = DeltaWidthDefault
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic signed [DELTA_WIDTH-1:0] left_count;
   logic signed [DELTA_WIDTH-1:0] right_count;
   logic [19:0]                   elapsed_us;
   logic signed [31:0]            set_x;
   logic signed [31:0]            set_y;
   logic signed [15:0]            set_heading;

   modport source (output valid, cmd, left_count, right_count, elapsed_us,
                   set_x, set_y, set_heading, input ready);
   modport sink (input valid, cmd, left_count, right_count, elapsed_us,
                 set_x, set_y, set_heading, output ready);
endinterface

// Handshake interface for result words of the odometry block.
interface ddos_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] heading;
   logic signed [31:0] lin_speed;
   logic signed [31:0] turn_rate;
   logic signed [31:0] slip_left_avg;
   logic signed [31:0] slip_right_avg;
   logic               slip_over;

   modport source (output valid, pos_x, pos_y, heading, lin_speed, turn_rate,
                   slip_left_avg, slip_right_avg, slip_over, input ready);
   modport sink (input valid, pos_x, pos_y, heading, lin_speed, turn_rate,
                 slip_left_avg, slip_right_avg, slip_over, output ready);
endinterface

/* rtl/diff_drive_odometry_slip.sv */
// Top level: differential-drive odometry with slip estimation, sequenced.
//
//   channel | port prefix | direction | contents
//   req     | req_        | in        | command, deltas, elapsed time, pose
//   rsp     | rsp_        | out       | pose, speeds, slips, slip flag
//   csr     | csr_        | in        | register index and write data
//
// An odometry tick offers its result after a setup step, the CORDIC rotation,
// the X and Y multiplies and two 72-bit restoring divisions through one shared
// subtractor (no divisions when the elapsed time is zero). A motor tick runs
// one turn multiply, then per wheel a start step, a division and a reciprocal
// multiply for the divide by ten (none of these when the elapsed time is zero).
// Set pose and unknown commands go straight to the result. Reset is synchronous
// and clears the pose, speeds and slips. The block takes one word at a time and
// holds its result until the sink takes it, then returns to idle before it
// takes the next word.
module diff_drive_odometry_slip
   import ddos_pkg::*;
#(
   parameter int DELTA_WIDTH = DeltaWidthDefault,
   parameter int ANGLE_WIDTH = AngleWidthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   ddos_req_if.sink                 req,
   ddos_rsp_if.source               rsp,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   localparam int DW = 72;
   // Magnitudes at or above ten times 2^31 saturate after the divide by ten.
   localparam logic signed [35:0] TenClamp = 36'sd21474836480;
   // Ceiling of 2^38 / 10; exact for every clamped magnitude.
   localparam logic signed [35:0] TenRecip = 36'sd27487790695;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_ODO    = 11'b00000000010,
      ST_CORDIC = 11'b00000000100,
      ST_MULXY  = 11'b00000001000,
      ST_DIV    = 11'b00000010000,
      ST_SPEED  = 11'b00000100000,
      ST_MOT0   = 11'b00001000000,
      ST_MOT1   = 11'b00010000000,
      ST_SLIP   = 11'b00100000000,
      ST_TEN    = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [23:0] odo_mm_ff, odo_ang_ff, mot_mm_ff, half_track_ff;
   logic [30:0] slip_lim_ff;

   // Architectural state.
   logic signed [31:0] x_ff, y_ff, speed_ff, rate_ff, slip_l_ff, slip_r_ff;
   logic [ANGLE_WIDTH-1:0] head_ff;

   // Working registers.
   logic signed [DELTA_WIDTH-1:0] dl_ff, dr_ff;
   logic [19:0] el_ff;
   logic signed [35:0] len_ff;
   logic signed [47:0] ang_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [32:0] cz_ff;
   logic flip_ff;
   logic [4:0] step_ff;
   logic [1:0] phase_ff;   // sub-step within a multi-pass operation
   logic side_ff;          // motor tick: 0 left, 1 right
   logic signed [40:0] expect_ff;   // turn speed term of the motor tick
   logic signed [71:0] nine_ff;     // slip sum before the divide by ten
   logic signed [35:0] ten_mag_ff;  // clamped magnitude of that sum
   logic ten_neg_ff;

   // Shared restoring divider on magnitudes.
   logic [DW-1:0] dividend_ff, divisor_ff, rem_ff, quo_ff;
   logic neg_ff;
   logic [6:0] dcount_ff;
   logic div_busy_ff;
   logic div_start;
   logic signed [DW-1:0] div_num;
   logic signed [DW-1:0] div_den;
   logic signed [DW-1:0] div_q;
   logic [DW:0] rem_shift;
   logic [DW:0] rem_sub;

   // Divider: one quotient bit per cycle.
   assign rem_shift = {rem_ff, dividend_ff[DW-1]};
   assign rem_sub   = rem_shift - {1'b0, divisor_ff};
   assign div_q     = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         dcount_ff <= '0;
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
         dcount_ff <= 7'(DW);
         dividend_ff <= div_num[DW-1] ? DW'(-div_num) : DW'(div_num);
         divisor_ff <= div_den[DW-1] ? DW'(-div_den) : DW'(div_den);
         neg_ff <= div_num[DW-1] ^ div_den[DW-1];
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (div_busy_ff) begin
         dividend_ff <= {dividend_ff[DW-2:0], 1'b0};
         if (!rem_sub[DW]) begin
            rem_ff <= rem_sub[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
         dcount_ff <= dcount_ff - 7'd1;
         if (dcount_ff == 7'd1) div_busy_ff <= 1'b0;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         odo_mm_ff <= 24'd3277;
         odo_ang_ff <= 24'd136710;
         mot_mm_ff <= 24'd3277;
         half_track_ff <= 24'd785;
         slip_lim_ff <= 31'd12800;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ODO_MM: odo_mm_ff <= csr_data[23:0];
            CSR_ODO_ANGLE: odo_ang_ff <= csr_data[23:0];
            CSR_MOTOR_MM: mot_mm_ff <= csr_data[23:0];
            CSR_HALF_TRACK: half_track_ff <= csr_data[23:0];
            CSR_SLIP_LIMIT: slip_lim_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Combinational helpers for the odometry front end.
   logic signed [DELTA_WIDTH:0] dsum, ddif;
   logic signed [63:0] len_raw, ang_raw;
   logic signed [35:0] len_clamp;
   logic [63:0] mid_full;
   logic [31:0] phase;
   logic [31:0] phase_rot;
   logic phase_flip;

   assign dsum = (DELTA_WIDTH + 1)'(dl_ff) + (DELTA_WIDTH + 1)'(dr_ff);
   assign ddif = (DELTA_WIDTH + 1)'(dr_ff) - (DELTA_WIDTH + 1)'(dl_ff);
   assign len_raw = (64'(dsum) * $signed({40'd0, odo_mm_ff}) + 64'sd256) >>> 9;
   assign ang_raw = 64'(ddif) * $signed({40'd0, odo_ang_ff});
   assign len_clamp = (len_raw > 64'sd17179869184) ? 36'sd17179869184 :
                      (len_raw < -64'sd17179869184) ? -36'sd17179869184 :
                      len_raw[35:0];

   always_comb begin
      mid_full = ({{(64-ANGLE_WIDTH){1'b0}}, head_ff} << 17) + 64'(ang_ff);
      if (ANGLE_WIDTH >= 15) phase = 32'(mid_full >> (ANGLE_WIDTH - 15));
      else phase = 32'(mid_full << (15 - ANGLE_WIDTH));
      phase_flip = (phase >= 32'h40000000) && (phase < 32'hC0000000);
      phase_rot = phase_flip ? phase + 32'h80000000 : phase;
   end

   // Shared multiplier for the position, turn and divide-by-ten products, operand selected by state.
   logic signed [35:0] mul_a;
   logic signed [35:0] mul_b;
   logic signed [71:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // Motor measurement and slip helpers.
   logic signed [DELTA_WIDTH-1:0] d_sel;
   logic signed [63:0] t_raw;
   logic signed [35:0] t_clamp;
   logic signed [31:0] slip_old;
   assign d_sel = side_ff ? dr_ff : dl_ff;
   assign t_raw = (64'(d_sel) * $signed({40'd0, mot_mm_ff}) + 64'sd128) >>> 8;
   assign t_clamp = (t_raw > 64'sd17179869184) ? 36'sd17179869184 :
                    (t_raw < -64'sd17179869184) ? -36'sd17179869184 :
                    t_raw[35:0];
   assign slip_old = side_ff ? slip_r_ff : slip_l_ff;

   logic signed [47:0] ang_clamp;
   assign ang_clamp = (ang_ff > 48'sd1099511627776) ? 48'sd1099511627776 :
                      (ang_ff < -48'sd1099511627776) ? -48'sd1099511627776 : ang_ff;

   logic signed [35:0] sx, sy;
   assign sx = cx_ff >>> step_ff[3:0];
   assign sy = cy_ff >>> step_ff[3:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MULXY: begin
            mul_a = len_ff;
            mul_b = (phase_ff == 2'd0) ? (flip_ff ? -cx_ff : cx_ff)
                                       : (flip_ff ? -cy_ff : cy_ff);
         end
         ST_MOT0: begin
            mul_a = 36'(rate_ff);
            mul_b = $signed({12'd0, half_track_ff});
         end
         ST_TEN: begin
            mul_a = ten_mag_ff;
            mul_b = TenRecip;
         end
         default: ;
      endcase
   end

   logic signed [71:0] mul_rnd;
   assign mul_rnd = (mul_p + 72'sd134217728) >>> 28;
   logic signed [71:0] turn_rnd;
   assign turn_rnd = (mul_p + 72'sd32768) >>> 16;

   // Expected speed for the wheel being processed, set before its division.
   logic signed [40:0] turn_val;
   assign turn_val = expect_ff;
   logic signed [41:0] expect_sel;
   assign expect_sel = side_ff ? 42'(speed_ff) + 42'(turn_val)
                               : 42'(speed_ff) - 42'(turn_val);

   // Divide by ten on the clamped magnitude, sign restored afterward.
   logic signed [71:0] nine_mag;
   logic signed [71:0] ten_q;
   assign nine_mag = nine_ff[71] ? -nine_ff : nine_ff;
   assign ten_q = ten_neg_ff ? -(mul_p >>> 38) : (mul_p >>> 38);

   // Sequencer.
   logic signed [31:0] x_in, y_in, speed_in, rate_in, sl_in, sr_in;
   logic [ANGLE_WIDTH-1:0] head_in;
   logic signed [71:0] nine_sum;

   assign nine_sum = 72'(slip_old) * 72'sd9 + 72'(expect_sel) - div_q;

   always_comb begin
      state_in = state_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = 72'sd1;
      x_in = x_ff;
      y_in = y_ff;
      head_in = head_ff;
      speed_in = speed_ff;
      rate_in = rate_ff;
      sl_in = slip_l_ff;
      sr_in = slip_r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               case (cmd_type'(req.cmd))
                  CMD_ODO: state_in = ST_ODO;
                  CMD_MOTOR: state_in = (req.elapsed_us == 20'd0) ? ST_OUT : ST_MOT0;
                  CMD_SET: begin
                     x_in = req.set_x;
                     y_in = req.set_y;
                     head_in = ANGLE_WIDTH'(32'(req.set_heading));
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_ODO: state_in = ST_CORDIC;
         ST_CORDIC: if (step_ff == 5'(CordicSteps - 1)) state_in = ST_MULXY;
         ST_MULXY: begin
            if (phase_ff == 2'd0) x_in = sat32(72'(x_ff) + mul_rnd);
            else begin
               y_in = sat32(72'(y_ff) + mul_rnd);
               head_in = head_ff + ANGLE_WIDTH'((ang_ff + 48'sd32768) >>> 16);
               if (el_ff == 20'd0) state_in = ST_OUT;
               else begin
                  div_start = 1'b1;
                  div_num = 72'(len_ff) * 72'sd1000000;
                  div_den = 72'(el_ff);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: if (!div_busy_ff) begin
            if (phase_ff == 2'd2) begin
               speed_in = sat32(div_q);
               div_start = 1'b1;
               div_num = 72'(ang_clamp) * 72'sd1000000;
               div_den = 72'(el_ff) * 72'sd256;
            end else begin
               rate_in = sat32(div_q);
               state_in = ST_OUT;
            end
         end
         ST_MOT0: state_in = ST_MOT1;
         ST_MOT1: begin
            div_start = 1'b1;
            div_num = 72'(t_clamp) * 72'sd1000000;
            div_den = 72'(el_ff);
            state_in = ST_SLIP;
         end
         ST_SLIP: if (!div_busy_ff) state_in = ST_TEN;
         ST_TEN: if (phase_ff != 2'd0) begin
            if (side_ff) begin
               sr_in = sat32(ten_q);
               state_in = ST_OUT;
            end else begin
               sl_in = sat32(ten_q);
               state_in = ST_MOT1;
            end
         end
         ST_OUT: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         x_ff <= '0; y_ff <= '0; head_ff <= '0;
         speed_ff <= '0; rate_ff <= '0; slip_l_ff <= '0; slip_r_ff <= '0;
         step_ff <= '0; phase_ff <= '0; side_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         x_ff <= x_in; y_ff <= y_in; head_ff <= head_in;
         speed_ff <= speed_in; rate_ff <= rate_in;
         slip_l_ff <= sl_in; slip_r_ff <= sr_in;
         case (state_ff)
            ST_IDLE: begin
               dl_ff <= req.left_count;
               dr_ff <= req.right_count;
               el_ff <= req.elapsed_us;
               phase_ff <= '0;
               side_ff <= 1'b0;
               step_ff <= '0;
            end
            ST_ODO: begin
               len_ff <= len_clamp;
               ang_ff <= ang_raw[47:0];
            end
            ST_CORDIC: begin
               if (step_ff == 5'd0 && phase_ff == 2'd0) begin
                  // Load the rotated phase, then iterate from the next cycle.
                  flip_ff <= phase_flip;
                  cx_ff <= 36'(CordicGain);
                  cy_ff <= '0;
                  cz_ff <= $signed({phase_rot[31], phase_rot});
                  phase_ff <= 2'd1;
               end else begin
                  if (!cz_ff[32]) begin
                     cx_ff <= cx_ff - sy;
                     cy_ff <= cy_ff + sx;
                     cz_ff <= cz_ff - 33'(atan_turn(step_ff[3:0]));
                  end else begin
                     cx_ff <= cx_ff + sy;
                     cy_ff <= cy_ff - sx;
                     cz_ff <= cz_ff + 33'(atan_turn(step_ff[3:0]));
                  end
                  if (step_ff == 5'(CordicSteps - 1)) phase_ff <= 2'd0;
                  else step_ff <= step_ff + 5'd1;
               end
            end
            ST_MULXY: phase_ff <= phase_ff + 2'd1;
            ST_DIV: if (!div_busy_ff) phase_ff <= phase_ff + 2'd1;
            ST_MOT0: expect_ff <= turn_rnd[40:0];
            ST_SLIP: if (!div_busy_ff) nine_ff <= nine_sum;
            ST_TEN: begin
               if (phase_ff == 2'd0) begin
                  ten_mag_ff <= (nine_mag > 72'(TenClamp)) ? TenClamp : nine_mag[35:0];
                  ten_neg_ff <= nine_ff[71];
                  phase_ff <= 2'd1;
               end else begin
                  side_ff <= 1'b1;
                  phase_ff <= 2'd0;
               end
            end
            default: ;
         endcase
      end
   end

   // Handshake and result.
   logic signed [32:0] abs_l, abs_r;
   assign abs_l = slip_l_ff[31] ? -33'(slip_l_ff) : 33'(slip_l_ff);
   assign abs_r = slip_r_ff[31] ? -33'(slip_r_ff) : 33'(slip_r_ff);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.pos_x = x_ff;
   assign rsp.pos_y = y_ff;
   assign rsp.heading = 16'(32'($signed(head_ff)));
   assign rsp.lin_speed = speed_ff;
   assign rsp.turn_rate = rate_ff;
   assign rsp.slip_left_avg = slip_l_ff;
   assign rsp.slip_right_avg = slip_r_ff;
   assign rsp.slip_over = (abs_l > $signed({2'b0, slip_lim_ff})) ||
                          (abs_r > $signed({2'b0, slip_lim_ff}));

endmodule

/* bench/testbench.sv */
// Self-checking bench for the slip-aware differential-drive odometry block.
module testbench
   import ddos_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 4000;
   localparam longint TravelLimit = 64'sd1 << 34;
   localparam longint AngleLimit = 64'sd1 << 40;

   typedef struct {
      cmd_type            cmd;
      logic signed [15:0] dl;
      logic signed [15:0] dr;
      logic [19:0]        el;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [15:0] sh;
   } tick_word;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [15:0] hd;
      logic signed [31:0] spd;
      logic signed [31:0] rate;
      logic signed [31:0] sl;
      logic signed [31:0] sr;
      logic               over;
   } pose_report;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   ddos_req_if req ();
   ddos_rsp_if rsp ();

   diff_drive_odometry_slip i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Register mirror and tracked pose, speeds and slips.
   logic [23:0] odo_mm, odo_ang, mot_mm, half_track;
   logic [30:0] slip_limit;
   longint pose_x, pose_y, speed_q8, rate_q8, slip_l, slip_r;
   logic [15:0] pose_hd;

   tick_word words_pending[$];
   pose_report reports_due[$];
   int mismatches = 0;
   int reports_seen = 0;
   int cmd_count[4] = '{0, 0, 0, 0};
   int quiet_cycles = 0;
   bit burst_mode = 1'b0;
   int send_gap = 0;
   int take_stall = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;

   // Arctangent of 2^-i in 32-bit turn units.
   localparam longint AtanTurn[16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680350, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41721, 20860
   };

   function automatic longint clamp_mag(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
   endfunction

   function automatic longint sat_word(longint v);
      return v > 64'sd2147483647 ? 64'sd2147483647
           : (v < -64'sd2147483648 ? -64'sd2147483648 : v);
   endfunction

   // Rotation-mode CORDIC on a 32-bit turn; results are Q28.
   function automatic void sin_cos(input logic [31:0] ph, output longint c,
                                   output longint s);
      longint x, y, z, nx;
      bit flip;
      flip = ph >= 32'h40000000 && ph < 32'hC0000000;
      if (flip) ph = ph + 32'h80000000;
      z = longint'($signed(ph));
      x = longint'(CordicGain);
      y = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z = z - AtanTurn[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z = z + AtanTurn[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint slip_update(longint old, longint want, longint d,
                                          longint el);
      longint t, meas;
      t = clamp_mag((d * longint'(mot_mm) + 128) >>> 8, TravelLimit);
      meas = t * 1000000 / el;
      return sat_word((9 * old + (want - meas)) / 10);
   endfunction

   // Advance the tracked state by one word and form the report it yields.
   function automatic pose_report advance_odometry(tick_word w);
      pose_report r;
      longint dl, dr, el, len, ang, c, s, turn;
      logic [63:0] mid;
      dl = longint'(w.dl);
      dr = longint'(w.dr);
      el = longint'(w.el);
      case (w.cmd)
         CMD_ODO: begin
            len = clamp_mag(((dl + dr) * longint'(odo_mm) + 256) >>> 9, TravelLimit);
            ang = (dr - dl) * longint'(odo_ang);
            mid = ({48'b0, pose_hd} << 17) + 64'(ang);
            sin_cos(mid[32:1], c, s);
            pose_x = sat_word(pose_x + ((len * c + (64'sd1 << 27)) >>> 28));
            pose_y = sat_word(pose_y + ((len * s + (64'sd1 << 27)) >>> 28));
            pose_hd = pose_hd + 16'((ang + 32768) >>> 16);
            if (el != 0) begin
               speed_q8 = sat_word(len * 1000000 / el);
               rate_q8 = sat_word(clamp_mag(ang, AngleLimit) * 1000000 / (el * 256));
            end
         end
         CMD_MOTOR: begin
            if (el != 0) begin
               turn = (rate_q8 * longint'(half_track) + 32768) >>> 16;
               slip_l = slip_update(slip_l, speed_q8 - turn, dl, el);
               slip_r = slip_update(slip_r, speed_q8 + turn, dr, el);
            end
         end
         CMD_SET: begin
            pose_x = longint'(w.sx);
            pose_y = longint'(w.sy);
            pose_hd = w.sh;
         end
         default: ;
      endcase
      r.px = pose_x[31:0];
      r.py = pose_y[31:0];
      r.hd = pose_hd;
      r.spd = speed_q8[31:0];
      r.rate = rate_q8[31:0];
      r.sl = slip_l[31:0];
      r.sr = slip_r[31:0];
      r.over = (slip_l < 0 ? -slip_l : slip_l) > longint'(slip_limit) ||
               (slip_r < 0 ? -slip_r : slip_r) > longint'(slip_limit);
      return r;
   endfunction

   // Sample both handshakes, predict accepted words and check results.
   always @(posedge clock) begin
      pose_report want;
      req_taken = req.valid && req.ready && !reset;
      rsp_taken = rsp.valid && rsp.ready && !reset;
      if (req_taken) begin
         tick_word w;
         w.cmd = cmd_type'(req.cmd);
         w.dl = req.left_count; w.dr = req.right_count; w.el = req.elapsed_us;
         w.sx = req.set_x; w.sy = req.set_y; w.sh = req.set_heading;
         cmd_count[req.cmd]++;
         reports_due.push_back(advance_odometry(w));
      end
      if (rsp_taken) begin
         reports_seen++;
         if (reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
         end else begin
            want = reports_due.pop_front();
            if (rsp.pos_x !== want.px || rsp.pos_y !== want.py ||
                rsp.heading !== want.hd || rsp.lin_speed !== want.spd ||
                rsp.turn_rate !== want.rate || rsp.slip_left_avg !== want.sl ||
                rsp.slip_right_avg !== want.sr || rsp.slip_over !== want.over) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  expected x=%0d y=%0d hd=%0d v=%0d w=%0d sl=%0d sr=%0d f=%0b",
                           want.px, want.py, want.hd, want.spd, want.rate,
                           want.sl, want.sr, want.over);
                  $display("  actual   x=%0d y=%0d hd=%0d v=%0d w=%0d sl=%0d sr=%0d f=%0b",
                           rsp.pos_x, rsp.pos_y, rsp.heading, rsp.lin_speed,
                           rsp.turn_rate, rsp.slip_left_avg, rsp.slip_right_avg,
                           rsp.slip_over);
               end
            end
         end
      end
      // Watchdog on cycles without any accepted word.
      if (req_taken || rsp_taken || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("timeout: no word accepted for %0d cycles", StallLimit);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Word driver with random gaps, and result taker with random stalls.
   always @(negedge clock) begin
      tick_word w;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req_taken || !req.valid) begin
         if (send_gap > 0 || words_pending.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req.valid <= 1'b0;
         end else begin
            w = words_pending.pop_front();
            req.valid <= 1'b1;
            req.cmd <= w.cmd;
            req.left_count <= w.dl;
            req.right_count <= w.dr;
            req.elapsed_us <= w.el;
            req.set_x <= w.sx;
            req.set_y <= w.sy;
            req.set_heading <= w.sh;
            if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
            send_gap = burst_mode ? 0 : $urandom_range(0, 4);
         end
      end
      if (rsp_taken) take_stall = burst_mode ? 0 : $urandom_range(0, 4);
      else if (take_stall > 0) take_stall--;
      rsp.ready <= (take_stall == 0);
   end

   function automatic tick_word make_word(cmd_type c, int dl, int dr, int el,
                                          int sx, int sy, int sh);
      tick_word w;
      w.cmd = c; w.dl = 16'(dl); w.dr = 16'(dr); w.el = 20'(el);
      w.sx = sx; w.sy = sy; w.sh = 16'(sh);
      return w;
   endfunction

   // Mostly realistic ticks with random content, plus noise and extremes.
   function automatic tick_word random_word();
      tick_word w;
      int pick;
      w.dl = 16'($urandom); w.dr = 16'($urandom); w.sx = $urandom; w.sy = $urandom;
      w.sh = 16'($urandom);
      pick = $urandom_range(0, 99);
      w.cmd = pick < 45 ? CMD_ODO : pick < 85 ? CMD_MOTOR : pick < 96 ? CMD_SET : CMD_NONE;
      if ($urandom_range(0, 2) != 0) begin
         w.dl = 16'($signed($urandom_range(0, 400)) - 200);
         w.dr = w.dl + 16'($signed($urandom_range(0, 40)) - 20);
      end
      pick = $urandom_range(0, 19);
      w.el = pick == 0 ? 20'd0 : pick < 4 ? 20'($urandom_range(1, 50))
           : pick < 15 ? 20'($urandom_range(1000, 50000)) : 20'($urandom);
      return w;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [30:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_ODO_MM: odo_mm = value[23:0];
         CSR_ODO_ANGLE: odo_ang = value[23:0];
         CSR_MOTOR_MM: mot_mm = value[23:0];
         CSR_HALF_TRACK: half_track = value[23:0];
         default: slip_limit = value;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_all(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                          logic [23:0] d, logic [30:0] e);
      write_reg(CSR_ODO_MM, 31'(a));
      write_reg(CSR_ODO_ANGLE, 31'(b));
      write_reg(CSR_MOTOR_MM, 31'(c));
      write_reg(CSR_HALF_TRACK, 31'(d));
      write_reg(CSR_SLIP_LIMIT, e);
   endtask

   task automatic drain();
      while (words_pending.size() != 0 || req.valid || reports_due.size() != 0)
         @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic queue_random(int n);
      repeat (n) words_pending.push_back(random_word());
   endtask

   initial begin
      odo_mm = 24'd3277; odo_ang = 24'd136710; mot_mm = 24'd3277;
      half_track = 24'd785; slip_limit = 31'd12800;
      pose_x = 0; pose_y = 0; pose_hd = '0;
      speed_q8 = 0; rate_q8 = 0; slip_l = 0; slip_r = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed words under reset register values.
      words_pending.push_back(make_word(CMD_NONE, 0, 0, 0, 0, 0, 0));
      words_pending.push_back(make_word(CMD_ODO, 100, 100, 0, 0, 0, 0));
      words_pending.push_back(make_word(CMD_ODO, 100, 120, 1000, 0, 0, 0));
      words_pending.push_back(make_word(CMD_MOTOR, 90, 130, 1000, 0, 0, 0));
      words_pending.push_back(make_word(CMD_MOTOR, 5, 5, 0, 0, 0, 0));
      words_pending.push_back(make_word(CMD_ODO, 32767, 32767, 1, 0, 0, 0));
      words_pending.push_back(make_word(CMD_ODO, -32768, 32767, 1048575, 0, 0, 0));
      words_pending.push_back(make_word(CMD_MOTOR, -32768, 32767, 1, 0, 0, 0));
      words_pending.push_back(make_word(CMD_SET, 0, 0, 0, 32'h7FFFFF00, 32'h80000100, 0));
      words_pending.push_back(make_word(CMD_ODO, 32767, 32767, 3, 0, 0, 0));
      words_pending.push_back(make_word(CMD_SET, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF,
                                        -32768));
      words_pending.push_back(make_word(CMD_ODO, -32768, -32768, 7, 0, 0, 0));
      words_pending.push_back(make_word(CMD_SET, -1, -1, 1048575, -1, -1, 32767));
      words_pending.push_back(make_word(CMD_ODO, -1, 1, 20, 0, 0, 0));
      words_pending.push_back(make_word(CMD_SET, 0, 0, 0, 0, 0, 16384));
      words_pending.push_back(make_word(CMD_ODO, 300, -300, 500, 0, 0, 0));
      words_pending.push_back(make_word(CMD_MOTOR, 32767, -32768, 1048575, 0, 0, 0));
      words_pending.push_back(make_word(CMD_NONE, -1, -1, 1048575, -1, -1, -1));
      drain();
      queue_random(400);
      drain();

      // Largest register values.
      set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 31'h7FFFFFFF);
      queue_random(350);
      drain();

      // Zero registers: every motion and threshold collapses.
      set_all(24'd0, 24'd0, 24'd0, 24'd0, 31'd0);
      queue_random(250);
      drain();

      // Random register values.
      set_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              31'($urandom));
      queue_random(400);
      drain();

      // Back to typical values with a small threshold.
      set_all(24'd3277, 24'd136710, 24'd3277, 24'd785, 31'($urandom_range(0, 5000)));
      queue_random(400);
      drain();

      $display("Covered %0d odometry, %0d motor, %0d set-pose, %0d idle commands;",
               cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
      $display("%0d result words checked across five register settings.", reports_seen);
      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, reports_due.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
